// ===== rtl/core/dnt_pkg.sv =====
// Shared types and constants for the directory name table.
// No dependencies; imported by dnt_table, dnt_seq and directory_name_table_unit.
`default_nettype none

package dnt_pkg;

  // Stream field widths fixed by the request and result formats
  localparam int unsigned KEY_IN_W    = 64;
  localparam int unsigned SECTOR_IN_W = 16;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned INDEX_OUT_W = 6;
  localparam int unsigned IN_DATA_W   = 88;
  localparam int unsigned IN_USER_W   = 2;
  localparam int unsigned OUT_DATA_W  = 32;

  // Request codes
  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NEED_REC  = 3'd4
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } seq_state_e;

  // Table control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic add;
    logic del;
    logic add_dir;
  } tbl_cmd_t;

  // One result beat
  typedef struct packed {
    logic                   entry_is_dir;
    logic [SECTOR_IN_W-1:0] sector_out;
    logic [INDEX_OUT_W-1:0] entry_index;
    logic [STATUS_W-1:0]    status;
    logic                   success;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/dnt_table.sv =====
// Entry storage: valid and directory flags in flops, names and sectors in memories.
// Depends on dnt_pkg for the control struct.
`default_nettype none

module dnt_table #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned KEY_W       = 64,
  parameter int unsigned SECTOR_BITS = 16,
  parameter int unsigned IDX_W       = $clog2(ENTRIES)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  dnt_pkg::tbl_cmd_t      tbl_cmd_i,
  input  wire  [IDX_W-1:0]       rd_addr_i,
  input  wire  [IDX_W-1:0]       wr_addr_i,
  input  wire  [KEY_W-1:0]       wr_name_i,
  input  wire  [SECTOR_BITS-1:0] wr_sector_i,
  output logic                   rd_valid_o,
  output logic                   rd_dir_o,
  output logic [KEY_W-1:0]       rd_name_o,
  output logic [SECTOR_BITS-1:0] rd_sector_o
);
  import dnt_pkg::*;

  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dir_q;
  logic [KEY_W-1:0]       name_mem   [ENTRIES];
  logic [SECTOR_BITS-1:0] sector_mem [ENTRIES];

  // Set flags on add, drop them on remove
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dir_q   <= '0;
    end else if (tbl_cmd_i.add) begin
      valid_q[wr_addr_i] <= 1'b1;
      dir_q[wr_addr_i]   <= tbl_cmd_i.add_dir;
    end else if (tbl_cmd_i.del) begin
      valid_q[wr_addr_i] <= 1'b0;
      dir_q[wr_addr_i]   <= 1'b0;
    end
  end

  // Registered flag read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_o <= 1'b0;
      rd_dir_o   <= 1'b0;
    end else if (tbl_cmd_i.rd_en) begin
      rd_valid_o <= valid_q[rd_addr_i];
      rd_dir_o   <= dir_q[rd_addr_i];
    end
  end

  // Name and sector memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (tbl_cmd_i.add) begin
      name_mem[wr_addr_i]   <= wr_name_i;
      sector_mem[wr_addr_i] <= wr_sector_i;
    end
    if (tbl_cmd_i.rd_en) begin
      rd_name_o   <= name_mem[rd_addr_i];
      rd_sector_o <= sector_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/dnt_seq.sv =====
// Request sequencer: walks every table entry through one shared key comparator,
// tracks the first match and first free slot, then builds the result and update.
// Depends on dnt_pkg.
`default_nettype none

module dnt_seq #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned KEY_W       = 64,
  parameter int unsigned SECTOR_BITS = 16,
  parameter int unsigned IDX_W       = $clog2(ENTRIES)
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // request side
  input  wire                                start_i,
  output logic                               ready_o,
  input  wire  [1:0]                         cmd_i,
  input  wire  [KEY_W-1:0]                   key_i,
  input  wire  [dnt_pkg::SECTOR_IN_W-1:0]    sector_i,
  input  wire                                dir_i,
  input  wire                                rec_i,
  // table side
  output dnt_pkg::tbl_cmd_t                  tbl_cmd_o,
  output logic [IDX_W-1:0]                   rd_addr_o,
  output logic [IDX_W-1:0]                   wr_addr_o,
  output logic [KEY_W-1:0]                   wr_name_o,
  output logic [SECTOR_BITS-1:0]             wr_sector_o,
  input  wire                                rd_valid_i,
  input  wire                                rd_dir_i,
  input  wire  [KEY_W-1:0]                   rd_name_i,
  input  wire  [SECTOR_BITS-1:0]             rd_sector_i,
  // result side
  output logic                               res_valid_o,
  input  wire                                res_ready_i,
  output dnt_pkg::res_t                      res_o
);
  import dnt_pkg::*;

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  seq_state_e state_q, state_d;

  logic [CNT_W-1:0]       cnt_q;
  logic                   rd_vld_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [1:0]             cmd_q;
  logic [KEY_W-1:0]       key_q;
  logic [SECTOR_BITS-1:0] new_sector_q;
  logic                   new_dir_q;
  logic                   rec_q;
  logic                   hit_q;
  logic [IDX_W-1:0]       hit_idx_q;
  logic [SECTOR_BITS-1:0] hit_sector_q;
  logic                   hit_dir_q;
  logic                   free_found_q;
  logic [IDX_W-1:0]       free_idx_q;

  logic issue;
  logic last_rd;
  logic match;
  logic free_slot;
  logic commit;
  logic do_add;
  logic do_del;

  // Scan control and the shared comparator
  assign issue     = (state_q == ST_SCAN) && (cnt_q < CNT_W'(ENTRIES));
  assign last_rd   = rd_vld_q && (rd_idx_q == IDX_W'(ENTRIES - 1));
  assign match     = rd_vld_q && rd_valid_i && (rd_name_i == key_q);
  assign free_slot = rd_vld_q && !rd_valid_i;
  assign commit    = (state_q == ST_DONE) && res_ready_i;

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (last_rd) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      rd_vld_q     <= 1'b0;
      rd_idx_q     <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (issue) begin
        rd_idx_q <= cnt_q[IDX_W-1:0];
        cnt_q    <= cnt_q + 1'b1;
      end
      if (start_i && ready_o) begin
        cnt_q        <= '0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (match && !hit_q) hit_q <= 1'b1;
        if (free_slot && !free_found_q) free_found_q <= 1'b1;
      end
    end
  end

  // Request and match payload
  always_ff @(posedge clk_i) begin
    if (start_i && ready_o) begin
      cmd_q        <= cmd_i;
      key_q        <= key_i;
      new_sector_q <= SECTOR_BITS'(sector_i);
      new_dir_q    <= dir_i;
      rec_q        <= rec_i;
    end
    if (match && !hit_q) begin
      hit_idx_q    <= rd_idx_q;
      hit_sector_q <= rd_sector_i;
      hit_dir_q    <= rd_dir_i;
    end
    if (free_slot && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
  end

  // Build the result from the scan outcome
  always_comb begin
    res_o  = '0;
    do_add = 1'b0;
    do_del = 1'b0;
    res_o.status = ST_NOT_FOUND;
    unique case (cmd_q)
      CMD_FIND: begin
        if (hit_q) begin
          res_o.success      = 1'b1;
          res_o.status       = ST_OK;
          res_o.entry_index  = INDEX_OUT_W'(hit_idx_q);
          res_o.sector_out   = SECTOR_IN_W'(hit_sector_q);
          res_o.entry_is_dir = hit_dir_q;
        end
      end
      CMD_ADD: begin
        if (hit_q) begin
          res_o.status = ST_DUPLICATE;
        end else if (free_found_q) begin
          do_add             = 1'b1;
          res_o.success      = 1'b1;
          res_o.status       = ST_OK;
          res_o.entry_index  = INDEX_OUT_W'(free_idx_q);
          res_o.entry_is_dir = new_dir_q;
        end else begin
          res_o.status = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (hit_q && hit_dir_q && !rec_q) begin
          res_o.status = ST_NEED_REC;
        end else if (hit_q) begin
          do_del             = 1'b1;
          res_o.success      = 1'b1;
          res_o.status       = ST_OK;
          res_o.entry_index  = INDEX_OUT_W'(hit_idx_q);
          res_o.sector_out   = SECTOR_IN_W'(hit_sector_q);
          res_o.entry_is_dir = hit_dir_q;
        end
      end
      default: begin
        res_o.status = ST_NOT_FOUND;
      end
    endcase
  end

  // Table access
  assign tbl_cmd_o.rd_en   = issue;
  assign tbl_cmd_o.add     = commit && do_add;
  assign tbl_cmd_o.del     = commit && do_del;
  assign tbl_cmd_o.add_dir = new_dir_q;
  assign rd_addr_o         = cnt_q[IDX_W-1:0];
  assign wr_addr_o         = do_add ? free_idx_q : hit_idx_q;
  assign wr_name_o         = key_q;
  assign wr_sector_o       = new_sector_q;

  // Checks
  a_add_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd_o.add |-> (!hit_q && free_found_q))
    else $error("add issued without a free slot or on a duplicate");

  a_del_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd_o.del |-> hit_q)
    else $error("remove issued without a matching entry");

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tbl_cmd_o.add && tbl_cmd_o.del))
    else $error("add and remove in the same cycle");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("read data returned outside the scan");

  a_scan_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && last_rd) |=> (state_q == ST_DONE))
    else $error("scan did not finish after the last entry");

endmodule

`default_nettype wire

// ===== rtl/core/directory_name_table_unit.sv =====
// A request beat is answered after a scan that reads every table entry.
// Requests are taken one at a time, only while the sequencer is idle; the single key comparator visits each entry once.
// The result sits in an output register, so a new request is taken while it waits.
// Reset (rst_ni, async, active low) clears every valid and directory flag; no clearing pass.
// Names and sectors of never-written entries are never reported.
`default_nettype none

module directory_name_table_unit #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned SECTOR_BITS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // request stream
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] name_key, [79:64] new_sector, [80] new_is_dir, [81] recursive_ok
  input  wire  [dnt_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] command
  input  wire  [dnt_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [0] success, [3:1] status, [9:4] entry_index, [25:10] sector_out, [26] entry_is_dir
  output logic [dnt_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import dnt_pkg::*;

  localparam int unsigned KEY_W = 8 * NAME_CHARS;
  localparam int unsigned IDX_W = $clog2(ENTRIES);

  logic [KEY_IN_W-1:0]    raw_key;
  logic [KEY_W-1:0]       norm_key;
  logic                   start;
  logic                   seq_ready;
  tbl_cmd_t               tbl_cmd;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       wr_addr;
  logic [KEY_W-1:0]       wr_name;
  logic [SECTOR_BITS-1:0] wr_sector;
  logic                   rd_valid;
  logic                   rd_dir;
  logic [KEY_W-1:0]       rd_name;
  logic [SECTOR_BITS-1:0] rd_sector;
  logic                   res_valid;
  logic                   res_ready;
  res_t                   res;
  logic                   m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0]  m_data_q;

  assign raw_key       = s_axis_tdata[KEY_IN_W-1:0];
  assign s_axis_tready = seq_ready;
  assign start         = s_axis_tvalid && seq_ready;

  // Normalize the key: keep bytes up to the first zero byte
  always_comb begin
    logic stop;
    norm_key = '0;
    stop     = 1'b0;
    for (int c = 0; c < int'(NAME_CHARS); c++) begin
      if (raw_key[8*c +: 8] == 8'd0) stop = 1'b1;
      if (!stop) norm_key[8*c +: 8] = raw_key[8*c +: 8];
    end
  end

  dnt_seq #(
    .ENTRIES     (ENTRIES),
    .KEY_W       (KEY_W),
    .SECTOR_BITS (SECTOR_BITS),
    .IDX_W       (IDX_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .ready_o     (seq_ready),
    .cmd_i       (s_axis_tuser[1:0]),
    .key_i       (norm_key),
    .sector_i    (s_axis_tdata[KEY_IN_W +: SECTOR_IN_W]),
    .dir_i       (s_axis_tdata[KEY_IN_W + SECTOR_IN_W]),
    .rec_i       (s_axis_tdata[KEY_IN_W + SECTOR_IN_W + 1]),
    .tbl_cmd_o   (tbl_cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_name_o   (wr_name),
    .wr_sector_o (wr_sector),
    .rd_valid_i  (rd_valid),
    .rd_dir_i    (rd_dir),
    .rd_name_i   (rd_name),
    .rd_sector_i (rd_sector),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  dnt_table #(
    .ENTRIES     (ENTRIES),
    .KEY_W       (KEY_W),
    .SECTOR_BITS (SECTOR_BITS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tbl_cmd_i   (tbl_cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .wr_name_i   (wr_name),
    .wr_sector_i (wr_sector),
    .rd_valid_o  (rd_valid),
    .rd_dir_o    (rd_dir),
    .rd_name_o   (rd_name),
    .rd_sector_o (rd_sector)
  );

  // Output register: load a result when the slot is empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_axis_tready) m_valid_d = 1'b0;
    if (res_valid && res_ready) m_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= OUT_DATA_W'(res);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== sim/directory_name_table_unit_test.sv =====
// Self-checking testbench for directory_name_table_unit: find, add and remove requests
// against a predicted name table, with random stalls on both stream sides.
// Depends on dnt_pkg and directory_name_table_unit from the RTL.
`default_nettype none

module directory_name_table_unit_test;
  import dnt_pkg::*;

  localparam int SLOTS        = 64;
  localparam int NAME_POOL    = 96;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // Predicted name table plus the queue of results still owed by the block
  class dir_table_tracker;
    bit              slot_valid[SLOTS];
    bit              slot_dir[SLOTS];
    logic [63:0]     slot_name[SLOTS];
    logic [15:0]     slot_sector[SLOTS];
    res_t            pending_results[$];
    int              mismatches;
    int              results_checked;
    int              status_seen[5];

    // Keep bytes up to the first zero byte, as a terminated string
    function logic [63:0] trim_key(logic [63:0] raw);
      logic [63:0] key;
      key = '0;
      for (int c = 0; c < 8; c++) begin
        if (raw[8*c +: 8] == 8'd0) break;
        key[8*c +: 8] = raw[8*c +: 8];
      end
      return key;
    endfunction

    function int find_slot(logic [63:0] key);
      for (int i = 0; i < SLOTS; i++)
        if (slot_valid[i] && slot_name[i] == key) return i;
      return -1;
    endfunction

    // Work out the answer to one accepted request and update the table
    function void note_request(logic [1:0] cmd, logic [63:0] raw_key, logic [15:0] sector,
                               bit is_dir, bit rec);
      res_t        want;
      logic [63:0] key;
      int          hit;
      int          free_slot;
      want = '0;
      want.status = ST_NOT_FOUND;
      key = trim_key(raw_key);
      hit = find_slot(key);
      free_slot = -1;
      case (cmd)
        CMD_FIND: begin
          if (hit >= 0) begin
            want.success      = 1'b1;
            want.status       = ST_OK;
            want.entry_index  = hit[5:0];
            want.sector_out   = slot_sector[hit];
            want.entry_is_dir = slot_dir[hit];
          end
        end
        CMD_ADD: begin
          if (hit >= 0) begin
            want.status = ST_DUPLICATE;
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (!slot_valid[i] && free_slot < 0) free_slot = i;
            if (free_slot < 0) begin
              want.status = ST_FULL;
            end else begin
              slot_valid[free_slot]  = 1'b1;
              slot_dir[free_slot]    = is_dir;
              slot_name[free_slot]   = key;
              slot_sector[free_slot] = sector;
              want.success      = 1'b1;
              want.status       = ST_OK;
              want.entry_index  = free_slot[5:0];
              want.entry_is_dir = is_dir;
            end
          end
        end
        CMD_REMOVE: begin
          if (hit >= 0 && slot_dir[hit] && !rec) begin
            want.status = ST_NEED_REC;
          end else if (hit >= 0) begin
            want.success      = 1'b1;
            want.status       = ST_OK;
            want.entry_index  = hit[5:0];
            want.sector_out   = slot_sector[hit];
            want.entry_is_dir = slot_dir[hit];
            slot_valid[hit]   = 1'b0;
            slot_dir[hit]     = 1'b0;
          end
        end
        default: ;
      endcase
      pending_results.push_back(want);
    endfunction

    function void check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one result beat against the oldest outstanding answer
    function void check_result(logic [OUT_DATA_W-1:0] data);
      res_t got;
      res_t want;
      got = data[$bits(res_t)-1:0];
      if (pending_results.size() == 0) begin
        $error("result beat %h with no request outstanding", data);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (want.status < 5) status_seen[want.status]++;
      check_field("success", 64'(want.success), 64'(got.success));
      check_field("status", 64'(want.status), 64'(got.status));
      check_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
      check_field("sector_out", 64'(want.sector_out), 64'(got.sector_out));
      check_field("entry_is_dir", 64'(want.entry_is_dir), 64'(got.entry_is_dir));
      check_field("pad", 64'd0, 64'(data[OUT_DATA_W-1:$bits(res_t)]));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  dir_table_tracker tracker = new();
  logic [63:0]      name_pool[NAME_POOL];
  bit               quiet_phase = 1'b0;
  bit               long_hold_due = 1'b0;
  int               requests_sent = 0;

  directory_name_table_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 88) return $urandom_range(1, 6);
    if (pick < 97) return $urandom_range(7, 80);
    return $urandom_range(100, 250);
  endfunction

  // Fill the bytes after the terminator with random garbage
  function automatic logic [63:0] dress_key(logic [63:0] key);
    logic [63:0] raw;
    bit          ended;
    raw = key;
    ended = 1'b0;
    for (int c = 0; c < 8; c++) begin
      if (ended) raw[8*c +: 8] = 8'($urandom_range(0, 255));
      else if (key[8*c +: 8] == 8'd0) ended = 1'b1;
    end
    return raw;
  endfunction

  // Present one request beat, wait for acceptance, then idle at random
  task automatic send_request(input logic [1:0] cmd, input logic [63:0] raw_key,
                              input logic [15:0] sector, input bit is_dir, input bit rec);
    int gap;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {6'b0, rec, is_dir, sector, raw_key};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_request(cmd, raw_key, sector, is_dir, rec);
    requests_sent++;
    @(negedge clk_i);
    gap = quiet_phase ? 0 : idle_length();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Stop offering and hold until every owed result has been scored
  task automatic wait_all_results();
    s_axis_tvalid = 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Random requests, mostly on a small set of names so lookups hit
  task automatic run_phase(input int count, input int w_find, input int w_add,
                           input int w_remove);
    int          pick;
    logic [1:0]  cmd;
    logic [63:0] raw_key;
    logic [15:0] sector;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(1, w_find + w_add + w_remove);
      if ($urandom_range(0, 99) < 3) cmd = CMD_SPARE;
      else if (pick <= w_find) cmd = CMD_FIND;
      else if (pick <= w_find + w_add) cmd = CMD_ADD;
      else cmd = CMD_REMOVE;
      if ($urandom_range(0, 99) < 6) raw_key = {$urandom, $urandom};
      else if ($urandom_range(0, 1) == 0)
        raw_key = dress_key(name_pool[$urandom_range(0, NAME_POOL - 1)]);
      else raw_key = name_pool[$urandom_range(0, NAME_POOL - 1)];
      pick = $urandom_range(0, 9);
      sector = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      send_request(cmd, raw_key, sector, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Score every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_result(m_axis_tdata);
  end

  // Result side: random hold-offs, plus one long stretch on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (!quiet_phase && $urandom_range(0, 3) == 0) hold_left = idle_length();
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("directory_name_table_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int          len;
    logic [63:0] key;
    // Names of 1..8 nonzero bytes, with the odd empty one
    for (int p = 0; p < NAME_POOL; p++) begin
      len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
      key = '0;
      for (int c = 0; c < len; c++) key[8*c +: 8] = 8'($urandom_range(1, 255));
      name_pool[p] = key;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty table, empty name, all-ones name, directory refusal, garbage after terminator
    send_request(CMD_FIND,   64'h0, 16'h1234, 1'b0, 1'b0);
    send_request(CMD_REMOVE, 64'h0000_0000_0063_6261, 16'h0, 1'b0, 1'b1);
    send_request(CMD_ADD,    64'h0, 16'h0000, 1'b0, 1'b0);
    send_request(CMD_FIND,   64'hFFFF_FF00_0000_0000, 16'h0, 1'b1, 1'b1);
    send_request(CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b0);
    send_request(CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 16'h5555, 1'b0, 1'b1);
    send_request(CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b0);
    send_request(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b0);
    send_request(CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 1'b0, 1'b1);
    send_request(CMD_ADD,    64'hA5A5_A5A5_A500_6261, 16'hAAAA, 1'b0, 1'b0);
    send_request(CMD_FIND,   64'h0000_0000_0000_6261, 16'h0, 1'b0, 1'b0);
    send_request(CMD_ADD,    64'h5A5A_5A5A_5A00_6261, 16'h00FF, 1'b1, 1'b0);
    send_request(CMD_SPARE,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    send_request(CMD_REMOVE, 64'h0, 16'h0, 1'b0, 1'b0);
    send_request(CMD_FIND,   64'h0, 16'h0, 1'b0, 1'b0);
    send_request(CMD_ADD,    64'h0101_0101_0101_0101, 16'h8000, 1'b0, 1'b1);
    send_request(CMD_REMOVE, 64'h0000_0000_0000_6261, 16'h0, 1'b1, 1'b1);
    send_request(CMD_SPARE,  64'h0, 16'h0, 1'b0, 1'b0);
    send_request(CMD_FIND,   64'h0101_0101_0101_0101, 16'h0, 1'b0, 1'b0);
    wait_all_results();

    // Mostly adds: grow the table until it is full
    run_phase(200, 15, 75, 5);
    wait_all_results();

    // Mixed traffic, opening with a long result-side hold-off
    long_hold_due = 1'b1;
    run_phase(300, 35, 30, 30);
    wait_all_results();

    // Mostly removes: drain the table
    run_phase(150, 25, 10, 60);
    wait_all_results();

    // Back to back, no idling on either side
    quiet_phase = 1'b1;
    run_phase(180, 35, 35, 30);
    quiet_phase = 1'b0;
    s_axis_tvalid = 1'b0;

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests, %0d results checked; ok %0d, not found %0d, duplicate %0d,",
             requests_sent, tracker.results_checked, tracker.status_seen[ST_OK],
             tracker.status_seen[ST_NOT_FOUND], tracker.status_seen[ST_DUPLICATE]);
    $display("table full %0d, directory refused %0d", tracker.status_seen[ST_FULL],
             tracker.status_seen[ST_NEED_REC]);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
      $display("directory_name_table_unit verification clean");
    else
      $display("directory_name_table_unit verification failed");
    $finish;
  end

endmodule

`default_nettype wire
